// ===== rtl/wies_pkg.sv =====
// ----------------------------------------------------------------------------
// wies_pkg: shared types and constants of the weekly interval edge scheduler
// Command, job and result structures, operation codes, result codes and
// the state encoding of the execution unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wies_pkg;

  localparam int NUM_DAYS    = 7;
  localparam int DAY_W       = 3;
  localparam int TIME_W      = 17;
  localparam int ID_W        = 8;
  localparam int SLOT_W      = 4;
  localparam int KIND_W      = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REG   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNREG = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CHG   = 2'd3;

  localparam logic [1:0] RK_STATUS = 2'd0;
  localparam logic [1:0] RK_ON     = 2'd1;
  localparam logic [1:0] RK_OFF    = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_REG,
    OP_UNREG,
    OP_CHG
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_DRAIN
  } back_state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DAY_W-1:0]  day;
    logic [TIME_W-1:0] tick_time;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic [ID_W-1:0]   ident;
    logic              off_flag;
    logic [TIME_W-1:0] new_start;
    logic [TIME_W-1:0] new_end;
    logic [ID_W-1:0]   new_ident;
    logic              new_off_flag;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   edge_ident;
    logic [DAY_W-1:0]  edge_day;
    logic [TIME_W-1:0] edge_time;
    logic              last;
  } res_t;

  typedef struct packed {
    op_t  op;
    logic day_ok;
    cmd_t cmd;
  } job_t;

  typedef struct packed {
    logic [TIME_W-1:0] t_start;
    logic [TIME_W-1:0] t_end;
    logic [ID_W-1:0]   ident;
    logic              active;
    logic              disabled;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/wies_front.sv =====
// ----------------------------------------------------------------------------
// wies_front: command intake
// Accepts commands, decodes the operation and the day range and pushes the
// decoded job into the queue toward the execution unit.
// ----------------------------------------------------------------------------
`default_nettype none

module wies_front
  import wies_pkg::*;
(
  input  wire  logic start,
  output logic       busy,
  input  wire  cmd_t cmd,
  input  wire  logic q_full,
  output logic       q_push,
  output job_t       q_data
);

  assign busy   = q_full;
  assign q_push = start && !q_full;

  always_comb begin
    q_data.cmd    = cmd;
    q_data.day_ok = (cmd.day < DAY_W'(NUM_DAYS));
    case (cmd.kind)
      KIND_TICK:  q_data.op = OP_TICK;
      KIND_REG:   q_data.op = OP_REG;
      KIND_UNREG: q_data.op = OP_UNREG;
      KIND_CHG:   q_data.op = OP_CHG;
      default:    q_data.op = OP_TICK;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/wies_queue.sv =====
// ----------------------------------------------------------------------------
// wies_queue: job queue
// Short first-in first-out buffer between intake and execution so that
// each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module wies_queue
  import wies_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic push,
  input  wire  job_t push_data,
  output logic       full,
  input  wire  logic pop,
  output job_t       pop_data,
  output logic       empty
);

  job_t                slots_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr;
  logic [QUEUE_AW-1:0] rptr;
  logic [QUEUE_AW:0]   count;

  assign full     = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots_q[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots_q[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= (wptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= (rptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wies_back.sv =====
// ----------------------------------------------------------------------------
// wies_back: execution unit
// Walks the slots of one day through the interval memory, one slot per
// cycle, applies table edits and switching, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wies_back
  import wies_pkg::*;
#(
  parameter int SLOTS_PER_DAY = 16
) (
  input  wire  logic                clk,
  input  wire  logic                rst,
  input  wire  logic                q_empty,
  output logic                      q_pop,
  input  wire  job_t                q_data,
  input  wire  logic                cfg_we,
  input  wire  logic [NUM_DAYS-1:0] cfg_data,
  output logic                      result_valid,
  output res_t                      result
);

  localparam int DEPTH = NUM_DAYS * SLOTS_PER_DAY;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = (SLOTS_PER_DAY > 1) ? $clog2(SLOTS_PER_DAY) : 1;
  localparam int CW    = SW + 1;
  localparam logic [AW-1:0] SLOTS_A = AW'(SLOTS_PER_DAY);

  back_state_t          state;
  back_state_t          state_next;
  job_t                 cur;
  logic [AW-1:0]        base;
  logic [CW-1:0]        rd_idx;
  logic [SW-1:0]        ev_idx;
  logic                 ev_on;
  logic [DAY_W-1:0]     last_day;
  logic [TIME_W-1:0]    last_time;
  logic [NUM_DAYS-1:0]  mask;
  entry_t               mem [DEPTH];
  entry_t               rd_data;
  logic [DEPTH-1:0]     vbits;
  logic                 pend_valid;
  res_t                 pend;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        ev_addr;
  logic                 wr_en;
  entry_t               wr_data;
  logic                 vb_set;
  logic                 vb_clr;
  logic                 out_valid_next;
  res_t                 out_next;
  logic                 pend_set;
  logic                 pend_clr;
  res_t                 pend_new;
  logic                 last_upd;
  logic                 walk_step;
  logic                 walk_init;

  logic                 ev_vld;
  logic                 ev_last;
  logic [7:0]           mask_ext;
  logic                 day_off;
  logic [TIME_W-1:0]    tt;
  logic                 turn_on;
  logic                 turn_off;
  logic                 match;
  logic [SW+SLOT_W-1:0] slot_wide;
  logic [SLOT_W-1:0]    slot4;
  res_t                 edge_res;
  res_t                 ok_res;
  res_t                 fail_res;

  assign ev_addr   = base + AW'(ev_idx);
  assign rd_addr   = base + AW'(rd_idx[SW-1:0]);
  assign ev_vld    = vbits[ev_addr];
  assign ev_last   = (ev_idx == SW'(SLOTS_PER_DAY - 1));
  assign mask_ext  = {{(8 - NUM_DAYS){1'b0}}, mask};
  assign day_off   = mask_ext[cur.cmd.day];
  assign tt        = cur.cmd.tick_time;
  assign slot_wide = {{SLOT_W{1'b0}}, ev_idx};
  assign slot4     = slot_wide[SLOT_W-1:0];

  assign turn_on  = ev_vld && (tt > rd_data.t_start) && (tt < rd_data.t_end) &&
                    !rd_data.active && !rd_data.disabled && !day_off;
  assign turn_off = ev_vld && !turn_on && rd_data.active &&
                    ((tt > rd_data.t_end) || rd_data.disabled);
  assign match    = ev_vld && (rd_data.t_start == cur.cmd.start_time) &&
                    (rd_data.t_end == cur.cmd.end_time) &&
                    (rd_data.ident == cur.cmd.ident);

  always_comb begin
    edge_res             = '0;
    edge_res.result_kind = turn_on ? RK_ON : RK_OFF;
    edge_res.slot        = slot4;
    edge_res.edge_ident  = rd_data.ident;
    edge_res.edge_day    = cur.cmd.day;
    edge_res.edge_time   = tt;
    ok_res               = '0;
    ok_res.result_kind   = RK_STATUS;
    ok_res.ok            = 1'b1;
    ok_res.slot          = slot4;
    ok_res.last          = 1'b1;
    fail_res             = '0;
    fail_res.result_kind = RK_STATUS;
    fail_res.last        = 1'b1;
  end

  always_comb begin
    state_next     = state;
    q_pop          = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_data        = rd_data;
    vb_set         = 1'b0;
    vb_clr         = 1'b0;
    out_valid_next = 1'b0;
    out_next       = '0;
    pend_set       = 1'b0;
    pend_clr       = 1'b0;
    pend_new       = edge_res;
    last_upd       = 1'b0;
    walk_step      = 1'b0;
    walk_init      = 1'b0;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        walk_init = 1'b1;
        if (cur.op == OP_TICK) begin
          if (cur.cmd.day == last_day && cur.cmd.tick_time == last_time) begin
            state_next = S_IDLE;
          end else begin
            last_upd   = 1'b1;
            state_next = cur.day_ok ? S_WALK : S_IDLE;
          end
        end else if (!cur.day_ok) begin
          out_valid_next = 1'b1;
          out_next       = fail_res;
          state_next     = S_IDLE;
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        walk_step = 1'b1;
        rd_en     = (rd_idx < CW'(SLOTS_PER_DAY));
        if (ev_on) begin
          case (cur.op)
            OP_TICK: begin
              if (turn_on || turn_off) begin
                wr_en          = 1'b1;
                wr_data.active = turn_on;
                pend_set       = 1'b1;
                out_valid_next = pend_valid;
                out_next       = pend;
              end
              if (ev_last) begin
                state_next = S_DRAIN;
              end
            end
            OP_REG: begin
              if (!ev_vld) begin
                wr_en            = 1'b1;
                wr_data.t_start  = cur.cmd.start_time;
                wr_data.t_end    = cur.cmd.end_time;
                wr_data.ident    = cur.cmd.ident;
                wr_data.active   = 1'b0;
                wr_data.disabled = cur.cmd.off_flag;
                vb_set           = 1'b1;
                out_valid_next   = 1'b1;
                out_next         = ok_res;
                state_next       = S_IDLE;
              end else if (ev_last) begin
                out_valid_next = 1'b1;
                out_next       = fail_res;
                state_next     = S_IDLE;
              end
            end
            OP_UNREG: begin
              if (match) begin
                vb_clr         = 1'b1;
                out_valid_next = 1'b1;
                out_next       = ok_res;
                state_next     = S_IDLE;
              end else if (ev_last) begin
                out_valid_next = 1'b1;
                out_next       = fail_res;
                state_next     = S_IDLE;
              end
            end
            OP_CHG: begin
              if (match) begin
                wr_en            = 1'b1;
                wr_data.t_start  = cur.cmd.new_start;
                wr_data.t_end    = cur.cmd.new_end;
                wr_data.ident    = cur.cmd.new_ident;
                wr_data.active   = 1'b0;
                wr_data.disabled = cur.cmd.new_off_flag;
                out_valid_next   = 1'b1;
                out_next         = ok_res;
                state_next       = S_IDLE;
              end else if (ev_last) begin
                out_valid_next = 1'b1;
                out_next       = fail_res;
                state_next     = S_IDLE;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_DRAIN: begin
        if (pend_valid) begin
          out_valid_next = 1'b1;
          out_next       = pend;
          out_next.last  = 1'b1;
        end
        pend_clr   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur  <= q_data;
      base <= AW'(q_data.cmd.day) * SLOTS_A;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      ev_idx <= '0;
      ev_on  <= 1'b0;
    end else if (walk_init) begin
      rd_idx <= '0;
      ev_on  <= 1'b0;
    end else if (walk_step) begin
      rd_idx <= rd_idx + CW'(rd_en);
      ev_idx <= rd_idx[SW-1:0];
      ev_on  <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ev_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (vb_set) begin
      vbits[ev_addr] <= 1'b1;
    end else if (vb_clr) begin
      vbits[ev_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_day  <= '0;
      last_time <= '0;
    end else if (last_upd) begin
      last_day  <= cur.cmd.day;
      last_time <= cur.cmd.tick_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (cfg_we) begin
      mask <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (pend_set) begin
      pend_valid <= 1'b1;
    end else if (pend_clr) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_set) begin
      pend <= pend_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= out_next;
  end

endmodule

`default_nettype wire

// ===== rtl/weekly_interval_edge_scheduler.sv =====
// ----------------------------------------------------------------------------
// weekly_interval_edge_scheduler: weekly interval edge scheduler, top level
// Per-weekday interval tables with register, unregister and change
// commands, and ticks that report intervals switching on and off.
//
//   channel   signals                          transaction
//   command   start, busy, cmd                 start high and busy low
//   result    result_valid, result             result_valid high, one cycle
//   config    cfg_valid, cfg_ready, cfg_data   cfg_valid and cfg_ready high
//
// A command waits in a two-entry queue; the execution unit then walks the
// slots of the day for a tick or a table edit, one slot a cycle, through
// the single read port of the interval memory, and skips the walk for a
// repeated tick. busy rises while the queue is full. Results cannot be
// stalled. Reset clears all valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module weekly_interval_edge_scheduler
  import wies_pkg::*;
#(
  parameter int SLOTS_PER_DAY = 16
) (
  input  wire  logic                clk,
  input  wire  logic                rst,
  input  wire  logic                start,
  output logic                      busy,
  input  wire  cmd_t                cmd,
  output logic                      result_valid,
  output res_t                      result,
  input  wire  logic                cfg_valid,
  output logic                      cfg_ready,
  input  wire  logic [NUM_DAYS-1:0] cfg_data
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t q_in;
  job_t q_out;

  assign cfg_ready = 1'b1;

  wies_front u_front (
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  wies_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  wies_back #(
    .SLOTS_PER_DAY (SLOTS_PER_DAY)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_data       (q_out),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== rtl/wies_check.sv =====
// ----------------------------------------------------------------------------
// wies_check: port-level checker
// Watches the result port of the scheduler and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wies_check
  import wies_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic result_valid,
  input wire res_t result
);

  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result shown right after reset");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.result_kind == RK_STATUS) |-> result.last)
    else $error("status result not marked last");

  a_edge_not_ok: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.result_kind == RK_ON || result.result_kind == RK_OFF))
      |-> (!result.ok && result.edge_day != DAY_W'(NUM_DAYS)))
    else $error("edge result carries ok or an invalid day");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.result_kind == RK_STATUS && !result.ok)
      |-> (result.slot == '0 && result.edge_ident == '0 && result.edge_time == '0))
    else $error("failed status carries nonzero fields");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.result_kind == RK_STATUS || result.result_kind == RK_ON ||
                      result.result_kind == RK_OFF))
    else $error("unknown result kind");

endmodule

bind weekly_interval_edge_scheduler wies_check u_check (.*);

`default_nettype wire

// ===== tb/edge_schedule_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edge_schedule_checker: result checker for the weekly interval scheduler
// Watches the command, result and configuration channels, keeps its own copy
// of the weekday interval tables, works out the results owed for every
// accepted command and compares each result strobe field by field with the
// oldest one owed.
// ----------------------------------------------------------------------------
module edge_schedule_checker
  import wies_pkg::*;
#(
  parameter int SLOTS_PER_DAY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  cmd_t                cmd,
  input  logic                result_valid,
  input  res_t                result,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [NUM_DAYS-1:0] cfg_data,
  output int                  results_owed,
  output int                  mismatch_count
);

  logic              iv_valid  [NUM_DAYS][SLOTS_PER_DAY];
  logic [TIME_W-1:0] iv_start  [NUM_DAYS][SLOTS_PER_DAY];
  logic [TIME_W-1:0] iv_end    [NUM_DAYS][SLOTS_PER_DAY];
  logic [ID_W-1:0]   iv_ident  [NUM_DAYS][SLOTS_PER_DAY];
  logic              iv_active [NUM_DAYS][SLOTS_PER_DAY];
  logic              iv_off    [NUM_DAYS][SLOTS_PER_DAY];
  logic [DAY_W-1:0]  prev_day;
  logic [TIME_W-1:0] prev_time;
  logic [NUM_DAYS-1:0] day_mask;
  res_t owed_q[$];

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic apply_command(input cmd_t c);
    res_t r;
    int hit;
    int first;
    int i;
    logic day_off;
    hit = -1;
    first = owed_q.size();
    if (c.kind == KIND_TICK) begin
      if (c.day == prev_day && c.tick_time == prev_time) return;
      if (c.day < NUM_DAYS) begin
        day_off = day_mask[c.day];
        for (i = 0; i < SLOTS_PER_DAY; i++) begin
          if (iv_valid[c.day][i]) begin
            r = '0;
            r.slot = i[SLOT_W-1:0];
            r.edge_ident = iv_ident[c.day][i];
            r.edge_day = c.day;
            r.edge_time = c.tick_time;
            if (c.tick_time > iv_start[c.day][i] && c.tick_time < iv_end[c.day][i] &&
                !iv_active[c.day][i] && !iv_off[c.day][i] && !day_off) begin
              iv_active[c.day][i] = 1'b1;
              r.result_kind = RK_ON;
              owed_q.push_back(r);
            end else if (iv_active[c.day][i] &&
                         (c.tick_time > iv_end[c.day][i] || iv_off[c.day][i])) begin
              iv_active[c.day][i] = 1'b0;
              r.result_kind = RK_OFF;
              owed_q.push_back(r);
            end
          end
        end
      end
      prev_day = c.day;
      prev_time = c.tick_time;
      if (owed_q.size() > first) begin
        r = owed_q.pop_back();
        r.last = 1'b1;
        owed_q.push_back(r);
      end
      return;
    end
    if (c.day < NUM_DAYS) begin
      for (i = 0; i < SLOTS_PER_DAY && hit < 0; i++) begin
        if (c.kind == KIND_REG) begin
          if (!iv_valid[c.day][i]) hit = i;
        end else if (iv_valid[c.day][i] && iv_start[c.day][i] == c.start_time &&
                     iv_end[c.day][i] == c.end_time && iv_ident[c.day][i] == c.ident) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        iv_active[c.day][hit] = 1'b0;
        case (c.kind)
          KIND_REG: begin
            iv_valid[c.day][hit] = 1'b1;
            iv_start[c.day][hit] = c.start_time;
            iv_end[c.day][hit] = c.end_time;
            iv_ident[c.day][hit] = c.ident;
            iv_off[c.day][hit] = c.off_flag;
          end
          KIND_UNREG: begin
            iv_valid[c.day][hit] = 1'b0;
            iv_off[c.day][hit] = 1'b0;
          end
          default: begin
            iv_start[c.day][hit] = c.new_start;
            iv_end[c.day][hit] = c.new_end;
            iv_ident[c.day][hit] = c.new_ident;
            iv_off[c.day][hit] = c.new_off_flag;
          end
        endcase
      end
    end
    r = '0;
    r.result_kind = RK_STATUS;
    r.last = 1'b1;
    if (hit >= 0) begin
      r.ok = 1'b1;
      r.slot = hit[SLOT_W-1:0];
    end
    owed_q.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      for (int d = 0; d < NUM_DAYS; d++) begin
        for (int s = 0; s < SLOTS_PER_DAY; s++) begin
          iv_valid[d][s] = 1'b0;
          iv_start[d][s] = '0;
          iv_end[d][s] = '0;
          iv_ident[d][s] = '0;
          iv_active[d][s] = 1'b0;
          iv_off[d][s] = 1'b0;
        end
      end
      prev_day = '0;
      prev_time = '0;
      day_mask = '0;
      mismatch_count = 0;
      owed_q.delete();
    end else begin
      if (result_valid) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result: kind %0d slot %0d ident %0d",
                 result.result_kind, result.slot, result.edge_ident);
          mismatch_count++;
        end else begin
          want = owed_q.pop_front();
          check_field("result_kind", want.result_kind, result.result_kind);
          check_field("ok", want.ok, result.ok);
          check_field("slot", want.slot, result.slot);
          check_field("edge_ident", want.edge_ident, result.edge_ident);
          check_field("edge_day", want.edge_day, result.edge_day);
          check_field("edge_time", want.edge_time, result.edge_time);
          check_field("last", want.last, result.last);
        end
      end
      if (cfg_valid && cfg_ready) day_mask = cfg_data;
      if (start && !busy) apply_command(cmd);
    end
    results_owed <= owed_q.size();
  end

endmodule

// ===== tb/weekly_interval_edge_scheduler_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weekly_interval_edge_scheduler_test: testbench top of the interval scheduler
// Drives a directed opening (empty and full tables, the missing weekday,
// repeated ticks, changes and removals) and then phases of random edits and
// ticks aimed at stored intervals, under several day-disable masks and with
// random gaps between commands. The checker beside the block predicts and
// compares; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module weekly_interval_edge_scheduler_test
  import wies_pkg::*;
();

  localparam int SLOTS = 16;
  localparam int DRAIN_CYCLES = 3 * (SLOTS + 4) + 8;
  localparam int POOL = 32;
  localparam int PHASE_ITEMS = 25;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  cmd_t                cmd;
  logic                result_valid;
  res_t                result;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [NUM_DAYS-1:0] cfg_data;
  int                  results_owed;
  int                  mismatch_count;

  cmd_t              recent [POOL];
  int                recent_n;
  logic [DAY_W-1:0]  hot_a;
  logic [DAY_W-1:0]  hot_b;
  logic [DAY_W-1:0]  prev_tick_day;
  logic [TIME_W-1:0] prev_tick_time;
  bit                no_gaps;

  weekly_interval_edge_scheduler #(
    .SLOTS_PER_DAY(SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .result_valid(result_valid),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  edge_schedule_checker #(
    .SLOTS_PER_DAY(SLOTS)
  ) edge_check (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .result_valid(result_valid),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .results_owed(results_owed),
    .mismatch_count(mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic cmd_t noise_cmd();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(cmd_t)-1:0];
  endfunction

  function automatic cmd_t edit_cmd(input logic [KIND_W-1:0] kind, input int day,
                                    input int t, input int s, input int e, input int id);
    cmd_t c;
    c = '0;
    c.kind = kind;
    c.day = day[DAY_W-1:0];
    c.tick_time = t[TIME_W-1:0];
    c.start_time = s[TIME_W-1:0];
    c.end_time = e[TIME_W-1:0];
    c.ident = id[ID_W-1:0];
    return c;
  endfunction

  function automatic void pick_span(inout logic [TIME_W-1:0] s, inout logic [TIME_W-1:0] e);
    if ($urandom_range(0, 99) < 90) begin
      s = TIME_W'($urandom_range(0, 80000));
      e = s + TIME_W'($urandom_range(0, 6399));
    end
  endfunction

  function automatic cmd_t random_item();
    cmd_t c;
    cmd_t pick;
    int roll;
    int sel;
    roll = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    c = noise_cmd();
    pick = recent[$urandom_range(0, (recent_n < POOL ? recent_n : POOL) - 1)];
    if (sel < 85) c.day = $urandom_range(0, 1) ? hot_a : hot_b;
    else if (sel < 95) c.day = DAY_W'($urandom_range(0, NUM_DAYS - 1));
    else c.day = DAY_W'(NUM_DAYS);
    sel = $urandom_range(0, 99);
    if (roll < 45) begin
      c.kind = KIND_TICK;
      if (sel < 10) begin
        c.day = prev_tick_day;
        c.tick_time = prev_tick_time;
      end else if (sel < 70 && recent_n > 0) begin
        c.day = pick.day;
        case ($urandom_range(0, 6))
          0: c.tick_time = pick.start_time - 1'b1;
          1: c.tick_time = pick.start_time;
          2: c.tick_time = pick.start_time + 1'b1;
          3: c.tick_time = TIME_W'((int'(pick.start_time) + int'(pick.end_time)) / 2);
          4: c.tick_time = pick.end_time - 1'b1;
          5: c.tick_time = pick.end_time;
          default: c.tick_time = pick.end_time + 1'b1;
        endcase
      end else if (sel < 95) begin
        c.tick_time = TIME_W'($urandom_range(0, 86399));
      end
    end else if (roll < 75) begin
      c.kind = KIND_REG;
      pick_span(c.start_time, c.end_time);
    end else begin
      c.kind = (roll < 90) ? KIND_UNREG : KIND_CHG;
      if (sel < 80 && recent_n > 0) begin
        c.day = pick.day;
        c.start_time = pick.start_time;
        c.end_time = pick.end_time;
        c.ident = pick.ident;
      end
      pick_span(c.new_start, c.new_end);
    end
    return c;
  endfunction

  task automatic send(input cmd_t c);
    cmd_t kept;
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    kept = c;
    if (c.kind == KIND_TICK) begin
      prev_tick_day = c.day;
      prev_tick_time = c.tick_time;
    end else if (c.kind == KIND_REG || c.kind == KIND_CHG) begin
      if (c.kind == KIND_CHG) begin
        kept.start_time = c.new_start;
        kept.end_time = c.new_end;
        kept.ident = c.new_ident;
      end
      recent[recent_n % POOL] = kept;
      recent_n++;
    end
  endtask

  task automatic pause_random();
    int n;
    int roll;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 5) no_gaps = !no_gaps;
    if (no_gaps || roll < 50) n = 0;
    else if (roll < 85) n = $urandom_range(1, 3);
    else if (roll < 97) n = $urandom_range(4, 20);
    else n = $urandom_range(30, 100);
    if (n > 0) begin
      start <= 1'b0;
      cmd <= noise_cmd();
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(input logic [NUM_DAYS-1:0] m);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    cmd_t c;
    logic [NUM_DAYS-1:0] m;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    recent_n = 0;
    no_gaps = 1'b0;
    hot_a = 3'd5;
    hot_b = 3'd0;
    prev_tick_day = '0;
    prev_tick_time = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send(edit_cmd(KIND_TICK, 0, 0, 0, 0, 0));
    pause_random();
    send(edit_cmd(KIND_REG, NUM_DAYS, 0, 10, 20, 1));
    pause_random();
    send(edit_cmd(KIND_TICK, NUM_DAYS, 5, 0, 0, 0));
    pause_random();
    send(edit_cmd(KIND_TICK, NUM_DAYS, 5, 0, 0, 0));
    pause_random();
    for (int i = 0; i < SLOTS; i++) begin
      c = edit_cmd(KIND_REG, 5, 0, i * 10,
                   (i == 0) ? 86399 : (i == SLOTS - 1) ? 131071 : 1000 + i,
                   (i == SLOTS - 1) ? 255 : i * 16);
      send(c);
      pause_random();
    end
    send(edit_cmd(KIND_REG, 5, 0, 7, 8, 9));
    pause_random();
    send(edit_cmd(KIND_TICK, 5, 500, 0, 0, 0));
    pause_random();
    c = edit_cmd(KIND_CHG, 5, 0, 30, 1003, 48);
    c.new_start = '0;
    c.new_end = '1;
    c.new_ident = '1;
    c.new_off_flag = 1'b1;
    send(c);
    pause_random();
    send(edit_cmd(KIND_UNREG, 5, 0, 20, 1002, 32));
    pause_random();
    send(edit_cmd(KIND_UNREG, 5, 0, 20, 1002, 32));
    pause_random();
    send(edit_cmd(KIND_TICK, 5, 5000, 0, 0, 0));
    pause_random();
    c = edit_cmd(KIND_REG, 5, 0, 100, 9000, 77);
    c.off_flag = 1'b1;
    send(c);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: m = '1;
        1: m = '0;
        5: m = 7'h55;
        default: m = NUM_DAYS'($urandom());
      endcase
      write_mask(m);
      hot_a = DAY_W'($urandom_range(0, NUM_DAYS - 1));
      hot_b = DAY_W'($urandom_range(0, NUM_DAYS - 1));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send(random_item());
        pause_random();
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wies_pkg.sv
rtl/wies_front.sv
rtl/wies_queue.sv
rtl/wies_back.sv
rtl/weekly_interval_edge_scheduler.sv
rtl/wies_check.sv
tb/edge_schedule_checker.sv
tb/weekly_interval_edge_scheduler_test.sv
